// ===== rtl/mme_pkg.sv =====
package mme_pkg;

  localparam int CFG_W = 6;
  localparam int IDX_W = 5;
  localparam int VAL_W = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int C_W = 37;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [VAL_W-1:0] q88_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [C_W-1:0] c_t;

endpackage

// ===== rtl/matrix_multiply_engine.sv =====
// Dense square matrix product engine, C = A x B, over signed Q8.8 elements held in two
// single-port synchronous memories of DIM*DIM entries each. A load transaction (in_mode 0)
// writes one A and one B element at (row, col); loads with row or col at or beyond DIM are
// dropped. A read transaction (in_mode 1) returns C[row][col] in signed Q21.16 on 37 bits,
// the sum over k < n of A[row][k]*B[k][col] with n = min(size_in_use, DIM). A read occupies
// the block: the memories supply one A and one B operand per cycle, followed by a two-stage
// multiply-accumulate tail and the handover to the output register. A read with row or col
// at or beyond DIM, or with n of zero, returns zero without reading the memories.
// The finished result waits in the output register while further loads are taken.
// Elements must be loaded before a read uses them. size_in_use resets to 32 and is written
// through the cfg port; the user must do this while the block is idle, as it is not enforced.
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int DIM = 32
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_size_in_use,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  idx_t             in_row,
  input  idx_t             in_col,
  input  q88_t             in_a_value,
  input  q88_t             in_b_value,

  output logic             out_valid,
  input  logic             out_ready,
  output idx_t             out_row,
  output idx_t             out_col,
  output c_t               out_c_value
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW = $clog2(DEPTH);
  localparam int CW0 = $clog2(DIM + 1);
  localparam int CW = (CW0 > CFG_W) ? CW0 : CFG_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] size_r;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    a_addr_r, a_addr_nxt;
  logic [AW-1:0]    b_addr_r, b_addr_nxt;
  idx_t             row_r, col_r;
  c_t               acc_r, acc_nxt;

  q88_t             a_mem [DEPTH];
  q88_t             b_mem [DEPTH];
  q88_t             a_q_r, b_q_r;
  prod_t            prod_r;
  logic             v1_r, last1_r, v2_r, last2_r;

  logic             out_valid_r;
  idx_t             out_row_r, out_col_r;
  c_t               out_c_r;

  logic             in_fire, in_range, wr_en, rd_en, rd_last, out_load;
  logic [AW-1:0]    wr_addr;
  logic [CW-1:0]    size_ext, n_calc;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_c_value = out_c_r;

  assign in_range = (int'(in_row) < DIM) && (int'(in_col) < DIM);
  assign wr_addr  = AW'(in_row) * AW'(DIM) + AW'(in_col);
  assign wr_en    = in_fire && (in_mode == MODE_LOAD) && in_range;
  assign size_ext = CW'(size_r);
  assign n_calc   = (size_ext < CW'(DIM)) ? size_ext : CW'(DIM);
  assign rd_en    = (state_r == ST_RUN);
  assign rd_last  = (k_r == n_r - CW'(1));
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    a_addr_nxt = a_addr_r;
    b_addr_nxt = b_addr_r;
    acc_nxt    = acc_r;
    if (v2_r) begin
      acc_nxt = acc_r + C_W'(prod_r);
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_mode == MODE_READ)) begin
          n_nxt      = n_calc;
          k_nxt      = '0;
          a_addr_nxt = AW'(in_row) * AW'(DIM);
          b_addr_nxt = AW'(in_col);
          acc_nxt    = '0;
          if (in_range && (n_calc != '0)) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        k_nxt      = k_r + CW'(1);
        a_addr_nxt = a_addr_r + AW'(1);
        b_addr_nxt = b_addr_r + AW'(DIM);
        if (rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v2_r && last2_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[wr_addr] <= in_a_value;
      b_mem[wr_addr] <= in_b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_q_r <= a_mem[a_addr_r];
      b_q_r <= b_mem[b_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= a_q_r * b_q_r;
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    acc_r    <= acc_nxt;
    last1_r  <= rd_last;
    last2_r  <= last1_r;
    if (in_fire) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (out_load) begin
      out_row_r <= row_r;
      out_col_r <= col_r;
      out_c_r   <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_size_in_use;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/sv/tb_matrix_multiply_engine.sv =====
module tb_matrix_multiply_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import mme_pkg::*;

  localparam int DIM = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    idx_t row;
    idx_t col;
    c_t   value;
  } c_elem_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_size_in_use;
  logic             in_valid;
  logic             in_ready;
  logic             in_mode;
  idx_t             in_row;
  idx_t             in_col;
  q88_t             in_a_value;
  q88_t             in_b_value;
  logic             out_valid;
  logic             out_ready;
  idx_t             out_row;
  idx_t             out_col;
  c_t               out_c_value;

  q88_t             a_matrix [DIM][DIM];
  q88_t             b_matrix [DIM][DIM];
  bit               loaded [DIM][DIM];
  logic [CFG_W-1:0] size_q;
  c_elem_t          c_expected [$];
  int               errors;
  int               cycle_count;
  bit               quiet;
  int               tgt_row;
  int               tgt_col;

  matrix_multiply_engine #(.DIM(DIM)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_size_in_use (cfg_size_in_use),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_a_value      (in_a_value),
    .in_b_value      (in_b_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_c_value     (out_c_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_terms();
    return (size_q < DIM) ? int'(size_q) : DIM;
  endfunction

  function automatic c_t dot_product(idx_t r, idx_t c);
    c_t    acc;
    prod_t p;
    acc = '0;
    for (int k = 0; k < active_terms(); k++) begin
      p = a_matrix[r][k] * b_matrix[k][c];
      acc = acc + p;
    end
    return acc;
  endfunction

  function automatic q88_t rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return q88_t'($urandom);
    endcase
  endfunction

  function automatic bit readable(int r, int c);
    for (int k = 0; k < active_terms(); k++) begin
      if (!loaded[r][k] || !loaded[k][c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(logic mode, idx_t r, idx_t c, q88_t a, q88_t b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_row     <= r;
    in_col     <= c;
    in_a_value <= a;
    in_b_value <= b;
    do @(posedge clk); while (!in_ready);
    if (mode == MODE_LOAD) begin
      a_matrix[r][c] = a;
      b_matrix[r][c] = b;
      loaded[r][c]   = 1'b1;
    end else begin
      c_expected.push_back('{row: r, col: c, value: dot_product(r, c)});
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (c_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] sz);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_size_in_use <= sz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_q = sz;
    tgt_row = $urandom_range(0, DIM - 1);
    tgt_col = $urandom_range(0, DIM - 1);
  endtask

  // load what the current target still lacks, then read it; now and then a stray load
  task automatic step_toward_read();
    int miss_r;
    int miss_c;
    miss_r = -1;
    miss_c = -1;
    if ($urandom_range(0, 7) == 0) begin
      send_item(MODE_LOAD, idx_t'($urandom_range(0, DIM - 1)), idx_t'($urandom_range(0, DIM - 1)),
                rand_q88(), rand_q88());
      return;
    end
    for (int k = 0; k < active_terms() && miss_r < 0; k++) begin
      if (!loaded[tgt_row][k]) begin
        miss_r = tgt_row;
        miss_c = k;
      end else if (!loaded[k][tgt_col]) begin
        miss_r = k;
        miss_c = tgt_col;
      end
    end
    if (miss_r >= 0) begin
      send_item(MODE_LOAD, idx_t'(miss_r), idx_t'(miss_c), rand_q88(), rand_q88());
    end else begin
      send_item(MODE_READ, idx_t'(tgt_row), idx_t'(tgt_col), rand_q88(), rand_q88());
      tgt_row = $urandom_range(0, DIM - 1);
      tgt_col = $urandom_range(0, DIM - 1);
    end
  endtask

  task automatic run_phase(logic [CFG_W-1:0] sz, int count);
    write_size(sz);
    repeat (count) step_toward_read();
  endtask

  task automatic test_empty_sum();
    write_size('0);
    send_item(MODE_READ, 5'd0, 5'd0, '0, '0);
    send_item(MODE_READ, 5'd31, 5'd31, 16'sh7fff, 16'sh8000);
    send_item(MODE_READ, 5'd5, 5'd22, '0, '0);
  endtask

  task automatic test_field_extremes();
    write_size(6'd4);
    for (int k = 0; k < 4; k++) send_item(MODE_LOAD, 5'd0, idx_t'(k), 16'sh8000, 16'sh8000);
    for (int k = 1; k < 4; k++) send_item(MODE_LOAD, idx_t'(k), 5'd0, 16'sh8000, 16'sh8000);
    send_item(MODE_READ, 5'd0, 5'd0, '0, '0);
    send_item(MODE_LOAD, 5'd1, 5'd0, 16'sh7fff, 16'sh7fff);
    send_item(MODE_LOAD, 5'd2, 5'd0, '0, 16'sh7fff);
    send_item(MODE_LOAD, 5'd3, 5'd0, 16'shffff, 16'sh7fff);
    send_item(MODE_READ, 5'd0, 5'd0, '0, '0);
    write_size(6'd1);
    send_item(MODE_LOAD, 5'd31, 5'd0, 16'sh7fff, 16'sh0001);
    send_item(MODE_LOAD, 5'd0, 5'd31, 16'shffff, 16'sh8000);
    send_item(MODE_LOAD, 5'd31, 5'd31, 16'sh7fff, 16'shffff);
    send_item(MODE_READ, 5'd31, 5'd31, '0, '0);
    send_item(MODE_READ, 5'd0, 5'd0, '0, '0);
  endtask

  task automatic test_drain_pause();
    write_size(6'd3);
    repeat (12) begin
      step_toward_read();
      drain_results();
    end
  endtask

  task automatic test_random_sizes();
    run_phase(6'd2, 90);
    run_phase(6'd1, 70);
    run_phase(6'd5, 110);
    run_phase(6'd8, 110);
    run_phase(6'd3, 80);
    run_phase(6'd63, 160);
    run_phase(6'd6, 100);
    run_phase(6'd32, 60);
  endtask

  task automatic test_streaming();
    write_size(6'd2);
    quiet = 1'b1;
    repeat (50) step_toward_read();
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_size_in_use <= SIZE_RESET;
    in_valid        <= 1'b0;
    in_mode         <= MODE_LOAD;
    in_row          <= '0;
    in_col          <= '0;
    in_a_value      <= '0;
    in_b_value      <= '0;
    errors  = 0;
    quiet   = 1'b0;
    size_q  = SIZE_RESET;
    tgt_row = 0;
    tgt_col = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_sum();
    test_field_extremes();
    test_drain_pause();
    test_random_sizes();
    test_streaming();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    c_elem_t want;
    if (rst_n && out_valid && out_ready) begin
      if (c_expected.size() == 0) begin
        report_mismatch("unexpected result, c_value", longint'(out_c_value), 0);
      end else begin
        want = c_expected.pop_front();
        if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
        if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
        if (out_c_value !== want.value) begin
          report_mismatch("c_value", longint'(out_c_value), longint'(want.value));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
